// ===== rtl/core/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 transcoder: shared constants and the
// burst record that passes decoded code units from the decoder to the output stage.
// No dependencies.
package u8u16_pkg;

  localparam int unsigned MaxUnits = 4;

  localparam logic [15:0] REPL_UNIT = 16'hFFFD;
  localparam logic [20:0] MAX_POINT = 21'h10FFFF;
  localparam logic [20:0] PLANE_ONE = 21'h010000;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;  // 0xDC00 >> 10

  // Code units produced by one input byte, lowest index goes out first.
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] unit;
    logic [2:0]                count;
    logic                      last;
  } burst_t;

endpackage

// ===== rtl/core/u8u16_decode.sv =====
// Sequence decoder: holds the open UTF-8 sequence and turns one byte into
// a burst of up to four UTF-16 code units. Depends on u8u16_pkg.
module u8u16_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [7:0]         in_byte,
  input  logic               end_of_string,
  output u8u16_pkg::burst_t  burst
);
  import u8u16_pkg::*;

  logic [1:0]  needed_r, needed_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [20:0] point_r, point_nxt;

  // Sequence state only advances when the burst is taken by the output stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r <= '0;
      held_r   <= '0;
      point_r  <= '0;
    end else if (load) begin
      needed_r <= needed_nxt;
      held_r   <= held_nxt;
      point_r  <= point_nxt;
    end
  end

  // Decode one byte against the open sequence.
  always_comb begin
    logic [2:0]  n;
    logic        lead;
    logic [20:0] pp_c;
    logic [20:0] v;
    n          = '0;
    lead       = 1'b1;
    pp_c       = {point_r[14:0], in_byte[5:0]};
    v          = pp_c - PLANE_ONE;
    needed_nxt = needed_r;
    held_nxt   = held_r;
    point_nxt  = point_r;
    for (int i = 0; i < MaxUnits; i++) begin
      burst.unit[i] = REPL_UNIT;
    end

    if (needed_r != 2'd0) begin
      if (in_byte[7:6] == 2'b10) begin
        // Continuation byte: gather six more bits.
        lead       = 1'b0;
        point_nxt  = pp_c;
        held_nxt   = held_r + 2'd1;
        needed_nxt = needed_r - 2'd1;
        if (needed_r == 2'd1) begin
          if (pp_c[20:16] == 5'd0) begin
            burst.unit[0] = pp_c[15:0];
            n             = 3'd1;
          end else if (pp_c <= MAX_POINT) begin
            burst.unit[0] = {HI_SURR_TAG, v[19:10]};
            burst.unit[1] = {LO_SURR_TAG, v[9:0]};
            n             = 3'd2;
          end else begin
            n = 3'd1;
          end
          held_nxt  = '0;
          point_nxt = '0;
        end
      end else begin
        // Broken sequence: one replacement per held byte.
        n          = {1'b0, held_r};
        needed_nxt = '0;
        held_nxt   = '0;
        point_nxt  = '0;
      end
    end

    if (lead) begin
      if (in_byte[7] == 1'b0) begin
        burst.unit[n[1:0]] = {8'h00, in_byte};
        n                  = n + 3'd1;
      end else if (in_byte[7:5] == 3'b110) begin
        point_nxt  = {16'd0, in_byte[4:0]};
        needed_nxt = 2'd1;
        held_nxt   = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        point_nxt  = {17'd0, in_byte[3:0]};
        needed_nxt = 2'd2;
        held_nxt   = 2'd1;
      end else if (in_byte[7:3] == 5'b11110) begin
        point_nxt  = {18'd0, in_byte[2:0]};
        needed_nxt = 2'd3;
        held_nxt   = 2'd1;
      end else begin
        // Stray continuation or invalid lead byte; the slot already holds U+FFFD.
        n = n + 3'd1;
      end
    end

    // End of string: every byte still held becomes a replacement.
    if (end_of_string) begin
      n          = n + {1'b0, held_nxt};
      needed_nxt = '0;
      held_nxt   = '0;
      point_nxt  = '0;
    end

    burst.count = n;
    burst.last  = end_of_string;
  end

endmodule

// ===== rtl/core/u8u16_burst.sv =====
// Output stage: holds one burst of code units and hands them out one word
// per cycle on the result stream while the receiver is ready. Depends on u8u16_pkg.
module u8u16_burst (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  u8u16_pkg::burst_t  burst,
  output logic               free,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,   // [15:0] code_unit
  output logic               out_tlast    // last_unit
);
  import u8u16_pkg::*;

  logic [MaxUnits-1:0][15:0] unit_r;
  logic [2:0]                cnt_r;
  logic                      last_r;

  // Room for a new burst when empty, or once the last pending word leaves this cycle.
  assign free       = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready);
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = unit_r[0];
  assign out_tlast  = last_r && (cnt_r == 3'd1);

  // Pending count: reload on a new burst, otherwise count down per word taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= burst.count;
    end else if (out_tvalid && out_tready) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // Payload: the head word always sits in slot zero.
  always_ff @(posedge clk) begin
    if (load) begin
      unit_r <= burst.unit;
      last_r <= burst.last;
    end else if (out_tvalid && out_tready) begin
      for (int i = 0; i < MaxUnits - 1; i++) begin
        unit_r[i] <= unit_r[i+1];
      end
      unit_r[MaxUnits-1] <= REPL_UNIT;
    end
  end

endmodule

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder: input register, sequence
// decoder and output burst stage. Depends on u8u16_pkg, u8u16_decode, u8u16_burst.
//
// Use: UTF-8 bytes enter on the in_ stream, one byte per word, with in_tlast
// marking the final byte of a string. UTF-16 code units leave on the out_
// stream, one unit per word, with out_tlast on the final unit of the string.
// A byte gives zero to four units: nothing while a sequence is still open,
// one unit for a character up to U+FFFF, a surrogate pair up to U+10FFFF,
// one U+FFFD for a sequence above that, and U+FFFD for each byte of a broken
// sequence, each stray byte, and each byte still held when the string ends.
// Path: the first unit of a byte passes the input register, then the burst
// register, before it is offered on the out_ stream.
// Throughput: one byte per cycle while every byte gives at most one unit and
// the receiver takes every unit; a byte that gives more units holds the burst
// register until the last of them leaves, and the input waits meanwhile.
// Reset (rst_n low, synchronous) empties both registers and closes any open
// sequence. When the receiver stalls, the pending unit holds steady and the
// input register fills, after which in_tready drops.
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,    // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] code_unit
  output logic        out_tlast    // last_unit
);
  import u8u16_pkg::*;

  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       eos_r;
  logic       free;
  logic       load;
  burst_t     burst;

  assign load      = in_valid_r && free;
  assign in_tready = !in_valid_r || load;

  // Input register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      eos_r  <= in_tlast;
    end
  end

  u8u16_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .in_byte       (byte_r),
    .end_of_string (eos_r),
    .burst         (burst)
  );

  u8u16_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .burst      (burst),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/u8u16_checker.sv =====
// Port-level checks for the UTF-8 to UTF-16 transcoder, bound to the top level.
// Depends on utf8_to_utf16_transcoder only through its ports.
module u8u16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word shown just after reset");

  // The input only backs up behind a pending result word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result word changed");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_chk (.*);

// ===== tb/tb.sv =====
// Testbench for utf8_to_utf16_transcoder: streams UTF-8 bytes in, predicts the UTF-16 units and
// compares every unit that comes out. Depends on u8u16_pkg and the transcoder RTL only.
`timescale 1ns / 100ps

module tb;
  import u8u16_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_PCT    = 36;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned MAX_SHOWN   = 10;

  // Kinds of character that the stimulus encodes.
  typedef enum logic [1:0] {CH_ASCII, CH_TWO, CH_THREE, CH_FOUR} char_kind_t;

  // One expected code unit.
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
  } utf16_unit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_byte
  logic        in_tlast = 1'b0;    // end_of_string
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [15:0] code_unit
  logic        out_tlast;          // last_unit

  // Stimulus controls shared between the test tasks and the receiver.
  logic src_gaps = 1'b1;
  logic sink_gaps = 1'b1;
  logic stall_hold = 1'b0;

  // Decoder state of the predictor.
  logic [1:0]  need_cnt = '0;
  logic [1:0]  held_cnt = '0;
  logic [20:0] acc_point = '0;
  logic [15:0] step_units [4];
  int          step_n;

  utf16_unit_t pending_units [$];

  int unsigned cycle_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned units_checked = 0;
  int unsigned err_cnt = 0;

  utf8_to_utf16_transcoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor helpers: each call appends to the units of the current byte, four at most.
  function automatic void add_unit(logic [15:0] unit);
    if (step_n < 4) begin
      step_units[step_n] = unit;
      step_n++;
    end
  endfunction

  function automatic void add_point(logic [20:0] point);
    logic [20:0] offset;
    offset = point - PLANE_ONE;
    if (point <= 21'h00FFFF) begin
      add_unit(point[15:0]);
    end else if (point <= MAX_POINT) begin
      add_unit({HI_SURR_TAG, offset[19:10]});
      add_unit({LO_SURR_TAG, offset[9:0]});
    end else begin
      add_unit(REPL_UNIT);
    end
  endfunction

  // A broken or unfinished sequence is replaced byte by byte.
  function automatic void flush_held();
    for (int i = 0; i < held_cnt; i++) add_unit(REPL_UNIT);
    need_cnt = '0;
    held_cnt = '0;
    acc_point = '0;
  endfunction

  // Works out the units that one accepted byte gives and queues them.
  function automatic void predict_utf16(logic [7:0] b, logic eos);
    logic is_lead;
    utf16_unit_t exp_unit;
    is_lead = 1'b1;
    step_n = 0;
    if (need_cnt != 0) begin
      if (b[7:6] == 2'b10) begin
        is_lead = 1'b0;
        acc_point = {acc_point[14:0], b[5:0]};
        held_cnt = held_cnt + 2'd1;
        need_cnt = need_cnt - 2'd1;
        if (need_cnt == 0) begin
          add_point(acc_point);
          held_cnt = '0;
          acc_point = '0;
        end
      end else begin
        flush_held();
      end
    end
    if (is_lead) begin
      if (!b[7]) begin
        add_unit({8'h00, b});
      end else if (b[7:5] == 3'b110) begin
        acc_point = {16'd0, b[4:0]};
        need_cnt = 2'd1;
        held_cnt = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_point = {17'd0, b[3:0]};
        need_cnt = 2'd2;
        held_cnt = 2'd1;
      end else if (b[7:3] == 5'b11110) begin
        acc_point = {18'd0, b[2:0]};
        need_cnt = 2'd3;
        held_cnt = 2'd1;
      end else begin
        add_unit(REPL_UNIT);
      end
    end
    if (eos) flush_held();
    for (int i = 0; i < step_n; i++) begin
      exp_unit.unit = step_units[i];
      exp_unit.last = eos && (i == step_n - 1);
      pending_units.insert(pending_units.size(), exp_unit);
    end
  endfunction

  // Compares one received unit with the oldest expectation.
  function automatic void check_unit(logic [15:0] unit, logic last);
    utf16_unit_t exp_unit;
    if (pending_units.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_SHOWN)
        $display("ERROR: unexpected unit %h last %b at cycle %0d", unit, last, cycle_cnt);
    end else begin
      exp_unit = pending_units.pop_front();
      units_checked++;
      if (exp_unit.unit !== unit || exp_unit.last !== last) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("ERROR: unit %0d expected %h last %b, got %h last %b", units_checked,
                   exp_unit.unit, exp_unit.last, unit, last);
      end
    end
  endfunction

  // Watches both handshakes: bytes feed the predictor, units are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_utf16(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_unit(out_tdata, out_tlast);
    end
  end

  // Receiver: random stalls, or a long hold-off while stall_hold is set.
  always @(posedge clk) begin
    out_tready <= !stall_hold && !(sink_gaps && ($urandom_range(99) < IDLE_PCT));
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d units still expected", cycle_cnt,
               pending_units.size());
      $display("utf8_to_utf16_transcoder test failed");
      $finish;
    end
  end

  // Offers one byte and returns once it has been taken.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (src_gaps) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (eos) strings_sent++;
  endtask

  // Sends a string of random characters; noise_pct of them are stray bytes or cut short.
  task automatic send_text(input int n_chars, input int noise_pct);
    logic [7:0]  chr [4];
    int          len;
    logic [20:0] cp;
    char_kind_t  kind;
    int          pick;
    for (int c = 0; c < n_chars; c++) begin
      pick = $urandom_range(99);
      kind = pick < 40 ? CH_ASCII : pick < 60 ? CH_TWO : pick < 80 ? CH_THREE : CH_FOUR;
      cp = 21'($urandom_range(0, 21'h1FFFFF));
      if (kind == CH_FOUR && $urandom_range(99) < 80)
        cp = 21'($urandom_range(PLANE_ONE, MAX_POINT));
      case (kind)
        CH_ASCII: begin
          chr[0] = {1'b0, cp[6:0]};
          len = 1;
        end
        CH_TWO: begin
          chr[0] = {3'b110, cp[10:6]};
          chr[1] = {2'b10, cp[5:0]};
          len = 2;
        end
        CH_THREE: begin
          chr[0] = {4'b1110, cp[15:12]};
          chr[1] = {2'b10, cp[11:6]};
          chr[2] = {2'b10, cp[5:0]};
          len = 3;
        end
        default: begin
          chr[0] = {5'b11110, cp[20:18]};
          chr[1] = {2'b10, cp[17:12]};
          chr[2] = {2'b10, cp[11:6]};
          chr[3] = {2'b10, cp[5:0]};
          len = 4;
        end
      endcase
      // Noise: either a raw random byte or a sequence that stops early.
      if ($urandom_range(99) < noise_pct) begin
        if (len == 1 || $urandom_range(1)) begin
          chr[0] = 8'($urandom_range(255));
          len = 1;
        end else begin
          len = $urandom_range(1, len - 1);
        end
      end
      for (int i = 0; i < len; i++)
        send_byte(chr[i], (c == n_chars - 1) && (i == len - 1));
    end
  endtask

  // Lets the input go quiet and waits for every expected unit to arrive.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_units.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Extremes and the error cases, in seven short strings.
  task automatic test_directed();
    // Lowest and highest single-byte characters.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // Highest valid code point, as a surrogate pair.
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // Code point just above the Unicode range.
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    // Overlong two-byte NUL and a lone high surrogate pass straight through.
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b1);
    // Stray continuation, then the two ends of the invalid lead range.
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Three-byte sequence broken by an ASCII byte.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    // Four held bytes' worth of replacements: three held, then a lead cut by end of string.
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'hC2, 1'b1);
    drain();
  endtask

  // Mostly well-formed text with random content, some noise, both sides idling.
  task automatic test_random_text();
    int unsigned goal;
    goal = bytes_sent + 300;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    while (bytes_sent < goal) send_text($urandom_range(1, 10), 25);
    drain();
  endtask

  // Receiver holds off for a long stretch while text keeps coming, so the input stalls.
  task automatic test_backpressure();
    int unsigned goal;
    goal = bytes_sent + 60;
    fork
      begin
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_hold <= 1'b0;
      end
      begin
        while (bytes_sent < goal) send_text($urandom_range(2, 8), 20);
      end
    join
    drain();
  endtask

  // A long stretch at full rate on both sides.
  task automatic test_full_rate();
    int unsigned goal;
    goal = bytes_sent + 80;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    while (bytes_sent < goal) send_text($urandom_range(1, 12), 15);
    drain();
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_text();
    test_backpressure();
    test_full_rate();
    $display("Sent %0d bytes in %0d strings, checked %0d UTF-16 units", bytes_sent,
             strings_sent, units_checked);
    $display("Covered broken and stray bytes, surrogate pairs, stalls and a long hold-off");
    if (pending_units.size() != 0) begin
      err_cnt++;
      $display("ERROR: %0d units never arrived", pending_units.size());
    end
    if (err_cnt == 0) begin
      $display("utf8_to_utf16_transcoder test passed");
    end else begin
      $display("%0d mismatches in total", err_cnt);
      $display("utf8_to_utf16_transcoder test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_decode.sv
rtl/core/u8u16_burst.sv
rtl/core/utf8_to_utf16_transcoder.sv
rtl/core/u8u16_checker.sv
tb/tb.sv
